// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MEXP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mexp assertion failed");

// Condition that must never be seen outside reset.
`define MEXP_ASSERT_NEVER(label, clk, rst_n, cond) \
  `MEXP_ASSERT(label, clk, rst_n, !(cond))

`endif

// ===== sv/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Widths, reset constant and shared request type of the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned ModW    = 31;  // modulus and residue width
  localparam int unsigned FieldW  = 63;  // base and exponent width
  localparam int unsigned ProdW   = 2 * ModW;
  localparam int unsigned DivW    = 64;  // dividend width seen by the reducer
  localparam int unsigned StepBits = 4;  // dividend bits retired per cycle
  localparam int unsigned StepCnt = DivW / StepBits;
  localparam int unsigned CntW    = $clog2(StepCnt);

  localparam logic [ModW-1:0] ModulusReset = ModW'(1000000007);

  // Request into the shared multiply/reduce unit.
  typedef struct packed {
    logic start;    // launch one operation
    logic raw_sel;  // reduce the raw operand instead of the product
  } mexp_req_t;

endpackage

// ===== sv/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply modulo a programmable modulus, with a
// Fermat inverse command, built around one shared multiply/reduce unit.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// command   in         start, busy               command_i, base_i, exponent_i
// result    out        done_o (one-cycle strobe) residue_o
// config    in         cfg_valid_i, cfg_ready_o  cfg_data_i (modulus)
//
// The shared unit loads its dividend on launch and then reduces four dividend
// bits per cycle until all 64 are retired, and its result is then taken. A
// zero exponent is answered once the base is reduced; each exponent bit below
// the top set bit costs a multiply and a square when set and a square when
// clear, and the top set bit costs a multiply only. A modulus below two
// answers 0 without the shared unit. Reset restores the modulus to 1000000007.
// The result strobe cannot be stalled; config is taken when idle and no
// command is offered.
// ----------------------------------------------------------------------------
module modular_exponentiation (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command_i,
  input  logic [mexp_pkg::FieldW-1:0]  base_i,
  input  logic [mexp_pkg::FieldW-1:0]  exponent_i,
  output logic                         done_o,
  output logic [mexp_pkg::ModW-1:0]    residue_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mexp_pkg::ModW-1:0]    cfg_data_i
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_STEP,
    S_MUL,
    S_SQR,
    S_FIN
  } state_e;

  state_e           state_q;
  logic             busy_q;
  logic             done_q;
  logic [ModW-1:0]  residue_q;
  logic [ModW-1:0]  mod_q;
  logic [ModW-1:0]  acc_q;
  logic [ModW-1:0]  sq_q;
  logic [FieldW-1:0] exp_q;

  logic             accept;
  logic             mod_ok;
  mexp_req_t        unit_req;
  logic [ModW-1:0]  op_a;
  logic             unit_done;
  logic [ModW-1:0]  unit_res;

  assign accept      = start && !busy_q;
  assign mod_ok      = (mod_q >= ModW'(2));
  // Hold off a modulus write while busy or while a command transfer is offered.
  assign cfg_ready_o = !busy_q && !start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= ModulusReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mod_q <= cfg_data_i;
    end
  end

  // Launch the shared unit: base reduction on accept with a legal modulus, then
  // squares and multiplies as the exponent bits dictate.
  always_comb begin
    unit_req = '0;
    op_a     = sq_q;
    unique case (state_q)
      S_IDLE: begin
        unit_req.start   = accept && mod_ok;
        unit_req.raw_sel = 1'b1;
      end
      S_STEP: begin
        unit_req.start = (exp_q != '0);
        op_a           = exp_q[0] ? acc_q : sq_q;
      end
      S_MUL: begin
        unit_req.start = unit_done && (exp_q[FieldW-1:1] != '0);
      end
      default: begin
        unit_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      residue_q <= '0;
      acc_q     <= '0;
      sq_q      <= '0;
      exp_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            busy_q <= 1'b1;
            exp_q  <= command_i ? FieldW'(mod_q - ModW'(2)) : exponent_i;
            if (mod_ok) begin
              acc_q   <= ModW'(1);
              state_q <= S_BASE;
            end else begin
              acc_q   <= '0;
              state_q <= S_FIN;
            end
          end
        end
        S_BASE: begin
          if (unit_done) begin
            sq_q    <= unit_res;
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          if (exp_q == '0) begin
            residue_q <= acc_q;
            done_q    <= 1'b1;
            busy_q    <= 1'b0;
            state_q   <= S_IDLE;
          end else begin
            state_q <= exp_q[0] ? S_MUL : S_SQR;
          end
        end
        S_MUL: begin
          if (unit_done) begin
            acc_q <= unit_res;
            // Drop the last square when no exponent bits remain.
            if (exp_q[FieldW-1:1] == '0) begin
              residue_q <= unit_res;
              done_q    <= 1'b1;
              busy_q    <= 1'b0;
              state_q   <= S_IDLE;
            end else begin
              state_q <= S_SQR;
            end
          end
        end
        S_SQR: begin
          if (unit_done) begin
            sq_q    <= unit_res;
            exp_q   <= exp_q >> 1;
            state_q <= S_STEP;
          end
        end
        S_FIN: begin
          residue_q <= acc_q;
          done_q    <= 1'b1;
          busy_q    <= 1'b0;
          state_q   <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  mexp_mulred u_mulred (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .op_a_i (op_a),
    .op_b_i (sq_q),
    .raw_i  (base_i),
    .mod_i  (mod_q),
    .done_o (unit_done),
    .res_o  (unit_res)
  );

  assign busy      = busy_q;
  assign done_o    = done_q;
  assign residue_o = residue_q;

endmodule

// ===== sv/mexp_mulred.sv =====
// ----------------------------------------------------------------------------
// mexp_mulred
// Shared modular unit: a 31x31 multiply or a raw 63-bit load, then a
// restoring reduction modulo m, four dividend bits per cycle.
// ----------------------------------------------------------------------------
module mexp_mulred (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mexp_pkg::mexp_req_t          req_i,
  input  logic [mexp_pkg::ModW-1:0]    op_a_i,
  input  logic [mexp_pkg::ModW-1:0]    op_b_i,
  input  logic [mexp_pkg::FieldW-1:0]  raw_i,
  input  logic [mexp_pkg::ModW-1:0]    mod_i,
  output logic                         done_o,
  output logic [mexp_pkg::ModW-1:0]    res_o
);
  import mexp_pkg::*;

  logic [ProdW-1:0] prod;
  logic [DivW-1:0]  div_d, div_q;
  logic [ModW-1:0]  rem_d, rem_q;
  logic [CntW-1:0]  cnt_q;
  logic             active_q;
  logic             done_q;

  assign prod = ProdW'(op_a_i) * ProdW'(op_b_i);
  assign div_d = req_i.raw_sel ? DivW'(raw_i) : DivW'(prod);

  // Shift in the top dividend bits one at a time, subtract m when it fits.
  always_comb begin
    logic [ModW:0] t;
    rem_d = rem_q;
    for (int i = 0; i < StepBits; i++) begin
      t = {rem_d, div_q[DivW-1-i]};
      if (t >= {1'b0, mod_i}) begin
        t = t - {1'b0, mod_i};
      end
      rem_d = t[ModW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(StepCnt - 1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      div_q <= div_d;
      rem_q <= '0;
    end else if (active_q) begin
      div_q <= div_q << StepBits;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = rem_q;

endmodule

// ===== sv/mexp_checker.sv =====
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks of the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mexp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_i,
  input logic done_i,
  input logic cfg_valid_i,
  input logic cfg_ready_i
);

  // An accepted command makes the block busy.
  `MEXP_ASSERT(a_accept_busy, clk_i, rst_ni, (start_i && !busy_i) |=> busy_i)

  // The result strobe comes with the block going idle.
  `MEXP_ASSERT(a_done_idle, clk_i, rst_ni, done_i |-> !busy_i)

  // Busy only ends by delivering a result.
  `MEXP_ASSERT(a_fall_done, clk_i, rst_ni, $fell(busy_i) |-> done_i)

  // One result per command: strobes never come back to back.
  `MEXP_ASSERT(a_single_done, clk_i, rst_ni, done_i |=> !done_i)

  // Never transfer a modulus while a command is in flight.
  `MEXP_ASSERT_NEVER(a_cfg_idle, clk_i, rst_ni, cfg_valid_i && cfg_ready_i && busy_i)

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start),
  .busy_i      (busy),
  .done_i      (done_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_i (cfg_ready_o)
);

// ===== verif/modular_exponentiation_test.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_test
// Self-checking bench for the modular exponentiation block. A driver feeds
// power and inverse commands from a pending list with random gaps. A monitor
// compares every result strobe against a residue worked out at the moment of
// the command transfer. The modulus is reprogrammed between phases and covers
// its extremes, the out-of-range values zero and one, and a composite value.
// ----------------------------------------------------------------------------
module modular_exponentiation_test;

  import mexp_pkg::FieldW;
  import mexp_pkg::ModW;
  import mexp_pkg::ModulusReset;

  typedef enum logic {
    CmdPower   = 1'b0,
    CmdInverse = 1'b1
  } command_e;

  typedef struct {
    command_e          command;
    logic [FieldW-1:0] base;
    logic [FieldW-1:0] exponent;
  } exp_request_t;

  localparam logic [FieldW-1:0] FieldMax = '1;
  localparam logic [FieldW-1:0] FieldTop = {1'b1, {(FieldW-1){1'b0}}};
  localparam int unsigned       SettleCycles = 64;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  logic              command_i   = 1'b0;
  logic [FieldW-1:0] base_i      = '0;
  logic [FieldW-1:0] exponent_i  = '0;
  logic              done_o;
  logic [ModW-1:0]   residue_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [ModW-1:0]   cfg_data_i  = '0;

  exp_request_t      pending[$];
  logic [ModW-1:0]   residues_due[$];
  logic [ModW-1:0]   modulus_now = ModulusReset;

  int unsigned gap_left    = 0;
  int unsigned calm_left   = 0;
  int unsigned errors      = 0;
  int unsigned items_sent  = 0;
  int unsigned inverses    = 0;
  int unsigned moduli_used = 1;

  modular_exponentiation dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .command_i  (command_i),
    .base_i     (base_i),
    .exponent_i (exponent_i),
    .done_o     (done_o),
    .residue_o  (residue_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Right-to-left square-and-multiply; inverse raises to modulus - 2.
  function automatic logic [ModW-1:0] expected_residue(command_e cmd,
      logic [FieldW-1:0] base, logic [FieldW-1:0] expo, logic [ModW-1:0] m);
    logic [63:0] m64;
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] e;
    m64 = {33'b0, m};
    if (m64 < 64'd2) return '0;
    e = {1'b0, expo};
    if (cmd == CmdInverse) e = m64 - 64'd2;
    acc = 64'd1;
    sq  = {1'b0, base} % m64;
    while (e != 64'd0) begin
      if (e[0]) acc = (acc * sq) % m64;
      e  = e >> 1;
      sq = (sq * sq) % m64;
    end
    return acc[ModW-1:0];
  endfunction

  function automatic logic [FieldW-1:0] pick_base(logic [ModW-1:0] m);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: begin
        raw = {33'b0, m} * 64'($urandom_range(0, 1000));
        return raw[FieldW-1:0];
      end
      2: return FieldW'(m) - 1'b1;
      3: return FieldW'($urandom_range(0, 100));
      4: return raw[FieldW-1:0] >> $urandom_range(0, FieldW - 1);
      default: return raw[FieldW-1:0];
    endcase
  endfunction

  // Keep most exponents short; the block pays per exponent bit.
  function automatic logic [FieldW-1:0] pick_exponent();
    logic [63:0] raw;
    int unsigned span;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0: span = FieldW;
      1, 2: span = $urandom_range(17, 40);
      default: span = $urandom_range(0, 16);
    endcase
    if (span == 0) return '0;
    return raw[FieldW-1:0] >> (FieldW - span);
  endfunction

  task automatic queue_item(input command_e cmd, input logic [FieldW-1:0] base,
                            input logic [FieldW-1:0] expo);
    exp_request_t req;
    req.command  = cmd;
    req.base     = base;
    req.exponent = expo;
    pending.push_back(req);
  endtask

  task automatic queue_random(input int unsigned count);
    command_e cmd;
    for (int unsigned i = 0; i < count; i++) begin
      cmd = ($urandom_range(0, 9) < 3) ? CmdInverse : CmdPower;
      queue_item(cmd, pick_base(modulus_now), pick_exponent());
    end
  endtask

  // Wait until every command is sent and every residue has come back.
  task automatic drain();
    while (pending.size() != 0 || start || residues_due.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic set_modulus(input logic [ModW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    modulus_now = value;
    moduli_used++;
    @(negedge clk_i);
  endtask

  // Driver: present the next command once the previous one is transferred.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        residues_due.push_back(expected_residue(command_e'(command_i), base_i,
                                                exponent_i, modulus_now));
        items_sent++;
        if (command_i == CmdInverse) inverses++;
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else begin
          case ($urandom_range(0, 19))
            0: begin
              calm_left = $urandom_range(4, 12);
              gap_left  = 0;
            end
            1: gap_left = $urandom_range(40, 400);
            2, 3, 4, 5, 6: gap_left = 0;
            default: gap_left = $urandom_range(1, 4);
          endcase
        end
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending.size() != 0) begin
          exp_request_t req;
          req = pending.pop_front();
          start      <= 1'b1;
          command_i  <= req.command;
          base_i     <= req.base;
          exponent_i <= req.exponent;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be held off, so check each strobe as it comes.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (residues_due.size() == 0) begin
        errors++;
        $display("%0t unexpected residue: expected none, actual %0d", $time, residue_o);
      end else begin
        logic [ModW-1:0] want;
        want = residues_due.pop_front();
        if (residue_o !== want) begin
          errors++;
          $display("%0t residue mismatch: expected %0d, actual %0d",
                   $time, want, residue_o);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset modulus: zero exponent, zero base, bases congruent to zero, extreme operands and inverses.
    queue_item(CmdPower,   '0,       '0);
    queue_item(CmdPower,   FieldMax, FieldMax);
    queue_item(CmdPower,   '0,       FieldW'(5));
    queue_item(CmdPower,   FieldMax, '0);
    queue_item(CmdPower,   FieldW'(modulus_now), FieldW'(3));
    queue_item(CmdPower,   FieldW'(modulus_now) - 1'b1, FieldW'(2));
    queue_item(CmdPower,   FieldW'(2), FieldTop);
    queue_item(CmdPower,   FieldTop, {(FieldW/2 + 1){2'b01}});
    queue_item(CmdInverse, '0,       FieldW'(9));
    queue_item(CmdInverse, FieldW'(modulus_now), '0);
    queue_item(CmdInverse, FieldW'(1), FieldMax);
    queue_item(CmdInverse, FieldMax, FieldMax);
    queue_item(CmdInverse, FieldW'(2), '0);
    queue_random(40);
    drain();

    // Smallest legal modulus: inverse exponent is zero, so every inverse gives one.
    set_modulus(ModW'(2));
    queue_item(CmdInverse, FieldW'(4), FieldMax);
    queue_item(CmdInverse, FieldW'(3), '0);
    queue_item(CmdPower,   FieldW'(3), FieldW'(5));
    queue_item(CmdPower,   FieldW'(4), '0);
    queue_random(20);
    drain();

    set_modulus('1);
    queue_item(CmdInverse, FieldMax, '0);
    queue_item(CmdPower,   FieldMax, FieldMax);
    queue_item(CmdInverse, FieldW'(modulus_now) - 1'b1, FieldW'(1));
    queue_random(30);
    drain();

    // Out of range: every answer is zero.
    set_modulus(ModW'(1));
    queue_item(CmdPower,   FieldW'(5), '0);
    queue_item(CmdInverse, FieldW'(7), FieldW'(7));
    queue_random(12);
    drain();

    set_modulus('0);
    queue_item(CmdPower,   '0,       '0);
    queue_item(CmdInverse, FieldMax, FieldMax);
    queue_random(12);
    drain();

    // Composite modulus: the inverse command is just a power.
    set_modulus(ModW'(1000000));
    queue_item(CmdInverse, FieldW'(3), '0);
    queue_random(20);
    drain();

    set_modulus(ModW'(7));
    queue_random(20);
    drain();

    set_modulus(ModW'(65537));
    queue_random(25);
    drain();

    repeat (2) begin
      set_modulus(ModW'($urandom_range(2, 32'h7FFF_FFFF)));
      queue_random(22);
      drain();
    end

    set_modulus(ModW'(998244353));
    queue_random(25);
    drain();

    set_modulus(ModulusReset);
    queue_random(25);
    drain();

    repeat (SettleCycles) @(posedge clk_i);
    $display("Ran %0d commands (%0d inverse, %0d power) under %0d modulus settings,",
             items_sent, inverses, items_sent - inverses, moduli_used);
    $display("including moduli 0, 1, 2, 2^31-1 and a composite one; %0d mismatches.",
             errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Generous cap on the whole run.
  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
